[src/mfsf_pkg.sv]
// Shared types, constants and job format for the monochrome frame store filler.
package mfsf_pkg;

	localparam int CW = 12;
	localparam int DW = 11;
	localparam int EW = 24;
	localparam int QDEPTH = 2;
	localparam int DEF_MAX_WIDTH = 128;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam logic [7:0] WIDTH_RESET = 8'd128;
	localparam logic [6:0] HEIGHT_RESET = 7'd64;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_RECT  = 2'd1,
		ACT_TRI   = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [EW-1:0] edge_t;

	typedef struct packed {
		action_t                     kind;
		logic                        color;
		logic                        empty;
		crd_t                        x1;
		crd_t                        x2;
		crd_t                        y1;
		crd_t                        y2;
		logic [7:0]                  rad;
		logic [15:0]                 rr;
		logic [2:0][DW-1:0]          ea;
		logic [2:0][DW-1:0]          ec;
		logic [2:0][EW-1:0]          e0;
		logic [2:0]                  page;
		logic [6:0]                  column;
		logic                        col_ok;
		crd_t                        hlim;
	} job_t;

endpackage

[src/mfsf_front.sv]
// Command front end: captures a command, clamps its box and sets up edge terms.
module mfsf_front #(
	parameter int MAX_WIDTH = mfsf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mfsf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [1:0]          action,
	input  logic signed [9:0]   first_x,
	input  logic signed [9:0]   first_y,
	input  logic signed [9:0]   second_x,
	input  logic signed [9:0]   second_y,
	input  logic signed [9:0]   third_x,
	input  logic signed [9:0]   third_y,
	input  logic [7:0]          radius,
	input  logic                color,
	input  logic [2:0]          page,
	input  logic [6:0]          column,
	input  logic [7:0]          frame_width,
	input  logic [6:0]          frame_height,
	input  logic                q_full,
	output logic                front_busy,
	output logic                push,
	output mfsf_pkg::job_t      job
);
	import mfsf_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_BOX, F_MUL, F_PUSH} fstate_t;

	fstate_t state_q;

	action_t    act_q;
	crd_t       fx_q, fy_q, sx_q, sy_q, tx_q, ty_q;
	logic [7:0] rad_in_q;
	logic       color_q;
	logic [2:0] page_q;
	logic [6:0] column_q;

	job_t       jb_q;
	crd_t       ox_q [3];
	crd_t       oy_q [3];
	edge_t      pa_q [3];
	edge_t      pc_q [3];
	logic [15:0] rr_q;

	crd_t wlim, hlim, rx1, rx2, ry1, ry2, hw, hh, rv;
	crd_t mnx, mxx, mny, mxy, bx1, bx2, by1, by2, px0;
	crd_t vx [3];
	crd_t vy [3];
	job_t jb_d;

	function automatic crd_t min2(input crd_t a, input crd_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic crd_t max2(input crd_t a, input crd_t b);
		return (a > b) ? a : b;
	endfunction

	assign front_busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !q_full;

	always_comb begin
		wlim = (crd_t'(frame_width) < crd_t'(MAX_WIDTH)) ? crd_t'(frame_width) : crd_t'(MAX_WIDTH);
		hlim = (crd_t'(frame_height) < crd_t'(MAX_HEIGHT)) ? crd_t'(frame_height)
			: crd_t'(MAX_HEIGHT);
		vx[0] = fx_q;
		vx[1] = sx_q;
		vx[2] = tx_q;
		vy[0] = fy_q;
		vy[1] = sy_q;
		vy[2] = ty_q;

		rx1 = max2(fx_q, crd_t'(0));
		ry1 = max2(fy_q, crd_t'(0));
		rx2 = min2(fx_q + sx_q - crd_t'(1), wlim - crd_t'(1));
		ry2 = min2(fy_q + sy_q - crd_t'(1), hlim - crd_t'(1));
		hw = crd_t'(sx_q / 2);
		hh = crd_t'(sy_q / 2);
		rv = crd_t'({4'b0, rad_in_q});
		if (rv > hw) begin
			rv = hw;
		end
		if (rv > hh) begin
			rv = hh;
		end
		if (rv < crd_t'(0)) begin
			rv = crd_t'(0);
		end

		mnx = min2(min2(fx_q, sx_q), tx_q);
		mxx = max2(max2(fx_q, sx_q), tx_q);
		mny = min2(min2(fy_q, sy_q), ty_q);
		mxy = max2(max2(fy_q, sy_q), ty_q);

		if (act_q == ACT_TRI) begin
			bx1 = max2(mnx, crd_t'(0));
			by1 = max2(mny, crd_t'(0));
			bx2 = min2(mxx, wlim - crd_t'(1));
			by2 = min2(mxy, hlim - crd_t'(1));
		end else begin
			bx1 = rx1;
			by1 = ry1;
			bx2 = rx2;
			by2 = ry2;
		end
		px0 = crd_t'({bx1[CW-1:3], 3'b000});

		jb_d = '0;
		jb_d.kind = act_q;
		jb_d.color = color_q;
		jb_d.empty = (bx1 > bx2) || (by1 > by2);
		jb_d.x1 = bx1;
		jb_d.x2 = bx2;
		jb_d.y1 = by1;
		jb_d.y2 = by2;
		jb_d.rad = rv[7:0];
		for (int e = 0; e < 3; e++) begin
			jb_d.ea[e] = DW'(vy[(e + 1) % 3] - vy[e]);
			jb_d.ec[e] = DW'(vx[(e + 1) % 3] - vx[e]);
		end
		jb_d.page = page_q;
		jb_d.column = column_q;
		jb_d.col_ok = crd_t'({5'b0, column_q}) < wlim;
		jb_d.hlim = hlim;
	end

	always_comb begin
		job = jb_q;
		job.rr = rr_q;
		for (int e = 0; e < 3; e++) begin
			job.e0[e] = pa_q[e] - pc_q[e];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						state_q <= F_BOX;
					end
				end
				F_BOX:  state_q <= F_MUL;
				F_MUL:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && take) begin
			act_q <= action_t'(action);
			fx_q <= crd_t'(first_x);
			fy_q <= crd_t'(first_y);
			sx_q <= crd_t'(second_x);
			sy_q <= crd_t'(second_y);
			tx_q <= crd_t'(third_x);
			ty_q <= crd_t'(third_y);
			rad_in_q <= radius;
			color_q <= color;
			page_q <= page;
			column_q <= column;
		end
		if (state_q == F_BOX) begin
			jb_q <= jb_d;
			for (int e = 0; e < 3; e++) begin
				ox_q[e] <= px0 - vx[e];
				oy_q[e] <= by1 - vy[e];
			end
		end
		if (state_q == F_MUL) begin
			rr_q <= 16'(jb_q.rad) * 16'(jb_q.rad);
			for (int e = 0; e < 3; e++) begin
				pa_q[e] <= edge_t'(ox_q[e]) * edge_t'($signed(jb_q.ea[e]));
				pc_q[e] <= edge_t'(oy_q[e]) * edge_t'($signed(jb_q.ec[e]));
			end
		end
	end

endmodule

[src/mfsf_queue.sv]
// Two-entry job queue between the front end and the drawing engine.
module mfsf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mfsf_pkg::job_t      wr_job,
	input  logic                pop,
	output mfsf_pkg::job_t      head,
	output logic                full,
	output logic                empty
);
	import mfsf_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	job_t          slot_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_job;
		end
	end

endmodule

[src/mfsf_back.sv]
// Drawing engine: walks jobs a byte per cycle over the frame store and reports results.
module mfsf_back #(
	parameter int MAX_WIDTH = mfsf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mfsf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mfsf_pkg::job_t      head,
	input  logic                q_empty,
	output logic                pop,
	output logic                boot,
	output logic                done,
	output logic [7:0]          page_byte,
	output logic                was_read
);
	import mfsf_pkg::*;

	localparam int STRIDE = (MAX_WIDTH + 7) / 8;
	localparam int DEPTH = STRIDE * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic {B_IDLE, B_RUN} bstate_t;
	typedef enum logic [1:0] {OP_NOP, OP_ZERO, OP_WRITE, OP_READ} op_t;

	bstate_t state_q;
	logic    boot_q;
	job_t    cur_q;
	crd_t    y_q;
	logic [CW-4:0] bx_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    k_q;
	edge_t   ecur_q [3];
	edge_t   erow_q [3];

	logic          v_s1, last_s1, report_s1;
	op_t           op_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    mask_s1;
	logic          color_s1, use_s1;
	logic [2:0]    k_s1, col_s1;
	logic [7:0]    rdata_s1;
	logic [7:0]    acc_q;
	logic          done_q, was_read_q;
	logic [7:0]    page_byte_q;

	logic [7:0]    mem [DEPTH];

	action_t       kind;
	op_t           iss_op;
	logic [AW-1:0] iss_addr;
	logic          iss_last, iss_use;
	logic [7:0]    iss_mask;
	logic          row_end;
	logic [CW-4:0] bx_start, bx_end;
	crd_t          rad, px, dyw, dxw, x1r, x2r, y1r, y2r;
	logic          top, bot, lft, rgt, skip;
	logic [15:0]   dysq, dxsq;
	logic [2:0]    ge;
	edge_t         lane_e, kk;
	logic [7:0]    wdata, byte_now;
	logic          rbit;

	assign boot = boot_q;
	assign done = done_q;
	assign page_byte = page_byte_q;
	assign was_read = was_read_q;
	assign pop = (state_q == B_IDLE) && !q_empty && !v_s1;
	assign kind = boot_q ? ACT_CLEAR : cur_q.kind;
	assign bx_start = cur_q.x1[CW-1:3];
	assign bx_end = cur_q.x2[CW-1:3];
	assign row_end = (bx_q == bx_end);

	always_comb begin
		rad = crd_t'({4'b0, cur_q.rad});
		x1r = cur_q.x1 + rad;
		x2r = cur_q.x2 - rad;
		y1r = cur_q.y1 + rad;
		y2r = cur_q.y2 - rad;
		top = y_q < y1r;
		bot = y_q > y2r;
		dyw = top ? (y1r - y_q) : (y_q - y2r);
		dysq = 16'(dyw[7:0]) * 16'(dyw[7:0]);
		iss_mask = '0;
		for (int k = 0; k < 8; k++) begin
			px = crd_t'({bx_q, 3'(k)});
			lft = px < x1r;
			rgt = px > x2r;
			dxw = lft ? (x1r - px) : (px - x2r);
			dxsq = 16'(dxw[7:0]) * 16'(dxw[7:0]);
			skip = (lft || rgt) && (top || bot)
				&& ((17'(dxsq) + 17'(dysq)) > 17'(cur_q.rr));
			kk = edge_t'(k);
			for (int e = 0; e < 3; e++) begin
				lane_e = ecur_q[e] + edge_t'($signed(cur_q.ea[e])) * kk;
				ge[e] = !lane_e[EW-1];
			end
			if (px >= cur_q.x1 && px <= cur_q.x2) begin
				if (cur_q.kind == ACT_RECT) begin
					iss_mask[7-k] = !skip;
				end else begin
					iss_mask[7-k] = (&ge) || !(|ge);
				end
			end
		end
	end

	always_comb begin
		iss_op = OP_NOP;
		iss_addr = '0;
		iss_last = 1'b0;
		iss_use = 1'b0;
		if (state_q == B_RUN) begin
			case (kind)
				ACT_CLEAR: begin
					iss_op = OP_ZERO;
					iss_addr = clr_q;
					iss_last = (clr_q == AW'(DEPTH - 1));
				end
				ACT_READ: begin
					iss_op = OP_READ;
					iss_addr = AW'({cur_q.page, k_q}) * AW'(STRIDE) + AW'(cur_q.column[6:3]);
					iss_last = (k_q == 3'd7);
					iss_use = cur_q.col_ok && (crd_t'({cur_q.page, k_q}) < cur_q.hlim);
				end
				default: begin
					if (cur_q.empty) begin
						iss_last = 1'b1;
					end else begin
						iss_op = OP_WRITE;
						iss_addr = AW'($unsigned(y_q)) * AW'(STRIDE) + AW'(bx_q);
						iss_last = row_end && (y_q == cur_q.y2);
					end
				end
			endcase
		end
	end

	always_comb begin
		rbit = use_s1 && rdata_s1[~col_s1];
		byte_now = acc_q;
		byte_now[k_s1] = rbit;
		case (op_s1)
			OP_ZERO:  wdata = 8'h00;
			OP_WRITE: wdata = color_s1 ? (rdata_s1 | mask_s1) : (rdata_s1 & ~mask_s1);
			default:  wdata = rdata_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
			boot_q <= 1'b1;
			clr_q <= '0;
			k_q <= '0;
			y_q <= '0;
			bx_q <= '0;
			for (int e = 0; e < 3; e++) begin
				ecur_q[e] <= '0;
				erow_q[e] <= '0;
			end
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			report_s1 <= 1'b0;
			op_s1 <= OP_NOP;
			acc_q <= '0;
			done_q <= 1'b0;
			was_read_q <= 1'b0;
			page_byte_q <= '0;
		end else begin
			v_s1 <= (state_q == B_RUN);
			last_s1 <= iss_last;
			report_s1 <= !boot_q;
			op_s1 <= iss_op;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_RUN;
						clr_q <= '0;
						k_q <= '0;
						y_q <= head.y1;
						bx_q <= head.x1[CW-1:3];
						for (int e = 0; e < 3; e++) begin
							ecur_q[e] <= edge_t'(head.e0[e]);
							erow_q[e] <= edge_t'(head.e0[e]);
						end
					end
				end
				B_RUN: begin
					clr_q <= clr_q + 1'b1;
					k_q <= k_q + 1'b1;
					if (row_end) begin
						bx_q <= bx_start;
						y_q <= y_q + crd_t'(1);
						for (int e = 0; e < 3; e++) begin
							erow_q[e] <= erow_q[e] - edge_t'($signed(cur_q.ec[e]));
							ecur_q[e] <= erow_q[e] - edge_t'($signed(cur_q.ec[e]));
						end
					end else begin
						bx_q <= bx_q + 1'b1;
						for (int e = 0; e < 3; e++) begin
							ecur_q[e] <= ecur_q[e] + (edge_t'($signed(cur_q.ea[e])) <<< 3);
						end
					end
					if (iss_last) begin
						state_q <= B_IDLE;
						boot_q <= 1'b0;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (v_s1 && op_s1 == OP_READ) begin
				acc_q <= byte_now;
			end
			done_q <= v_s1 && last_s1 && report_s1;
			was_read_q <= (op_s1 == OP_READ);
			page_byte_q <= (op_s1 == OP_READ) ? byte_now : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		addr_s1 <= iss_addr;
		mask_s1 <= iss_mask;
		color_s1 <= cur_q.color;
		use_s1 <= iss_use;
		k_s1 <= k_q;
		col_s1 <= cur_q.column[2:0];
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[iss_addr];
		if (v_s1 && (op_s1 == OP_ZERO || op_s1 == OP_WRITE)) begin
			mem[addr_s1] <= wdata;
		end
	end

endmodule

[src/mono_framebuffer_shape_filler.sv]
// Top level: register port, command front end, job queue and drawing engine.
//
//   channel   direction  handshake                  payload
//   command   in         start && !busy             action .. column
//   result    out        done (one cycle strobe)    page_byte, was_read
//   config    in         psel&penable&pwrite        paddr, pwdata -> prdata
//
// The front end takes a command through box, multiply and push states, waiting in push
// while the queue is full, then hands it to a two-entry queue. Clear zeroes every store
// byte (STRIDE * MAX_HEIGHT, 1024 by default); a fill writes each byte of its clamped box,
// rows times bytes per row; a read gathers 8 rows of one column. Each job drains the store
// read-modify-write stage before the next is taken. After reset the store is zeroed, busy high.
// Results cannot be held off; busy stalls only the command side.
module mono_framebuffer_shape_filler #(
	parameter int MAX_WIDTH = mfsf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mfsf_pkg::DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [9:0]  first_x,
	input  logic signed [9:0]  first_y,
	input  logic signed [9:0]  second_x,
	input  logic signed [9:0]  second_y,
	input  logic signed [9:0]  third_x,
	input  logic signed [9:0]  third_y,
	input  logic [7:0]         radius,
	input  logic               color,
	input  logic [2:0]         page,
	input  logic [6:0]         column,
	output logic               done,
	output logic [7:0]         page_byte,
	output logic               was_read,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mfsf_pkg::*;

	logic [7:0] width_q;
	logic [6:0] height_q;
	logic       front_busy, boot, take;
	job_t       fr_job, q_head;
	logic       q_push, q_pop, q_full, q_empty;

	assign pready = 1'b1;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_HEIGHT) ? {25'b0, height_q} : {24'b0, width_q};
	assign busy = boot || front_busy;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_idx_t'(paddr[2]) == REG_HEIGHT) begin
				height_q <= pwdata[6:0];
			end else begin
				width_q <= pwdata[7:0];
			end
		end
	end

	mfsf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .action(action),
		.first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
		.third_x(third_x), .third_y(third_y), .radius(radius), .color(color),
		.page(page), .column(column), .frame_width(width_q), .frame_height(height_q),
		.q_full(q_full), .front_busy(front_busy), .push(q_push), .job(fr_job)
	);

	mfsf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .wr_job(fr_job), .pop(q_pop),
		.head(q_head), .full(q_full), .empty(q_empty)
	);

	mfsf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .head(q_head), .q_empty(q_empty), .pop(q_pop),
		.boot(boot), .done(done), .page_byte(page_byte), .was_read(was_read)
	);

	a_no_result_in_boot: assert property (@(posedge clk) disable iff (!arst_n)
		boot |-> !done) else $error("result during reset sweep");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue overflow");
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue underflow");
	a_draw_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !was_read) |-> (page_byte == 8'd0)) else $error("nonzero draw result");

endmodule
